[hw/rtl/ens_pkg.sv]
// ens_pkg: shared types and constants of the envelope note segmenter
// no dependencies; imported by every rtl module of the block
`default_nettype none

package ens_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 15;
	localparam int SUM_W    = 30;
	localparam int SCALED_W = 31;
	localparam int INDEX_W  = 32;
	localparam int SEG_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [WIN_W-1:0]    WINDOW_RESET    = 15'd10000;
	localparam logic [CFG_W-1:0]    THRESHOLD_RESET = 16'd1000;
	localparam logic [CFG_W-1:0]    FLOOR_RESET     = 16'd2000;
	localparam logic [CFG_W-1:0]    LIMIT_RESET     = 16'd1000;
	localparam logic [INDEX_W-1:0]  INDEX_MAX       = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH     = 2'd0,
		CFG_LEVEL_THRESHOLD   = 2'd1,
		CFG_FALL_SAMPLE_FLOOR = 2'd2,
		CFG_SEGMENT_LIMIT     = 2'd3
	} cfg_idx_t;

	// window stage output, one per item
	typedef struct packed {
		logic                valid;
		logic                start;
		logic                full;
		logic [SAMPLE_W-1:0] sample;
		logic [SUM_W-1:0]    sum;
	} win_item_t;

	// result payload, first field in the high bits
	typedef struct packed {
		logic [SEG_W-1:0]   segment_number;
		logic [INDEX_W-1:0] offset_idx;
		logic [INDEX_W-1:0] onset_idx;
	} seg_result_t;

	localparam int RESULT_W = $bits(seg_result_t);

endpackage

`default_nettype wire

[hw/rtl/ens_window.sv]
// ens_window: circular delay line memory and running window sum
// depends on ens_pkg; read-first ram, one read and one write per accepted sample
`default_nettype none

module ens_window #(
	parameter int WINDOW_MAX = 16384
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         accept,
	input  wire logic [ens_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         start,
	input  wire logic [ens_pkg::WIN_W-1:0]    win,
	input  wire logic                         clear,
	output ens_pkg::win_item_t                item_s2
);
	import ens_pkg::*;

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int DW = 17;
	localparam logic [DW-1:0] DEPTH = DW'(WINDOW_MAX);

	logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

	logic [AW-1:0]       wp_q;
	logic [WIN_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;

	logic [AW-1:0]       wp_base;
	logic [WIN_W-1:0]    fill_base;
	logic [WIN_W-1:0]    fill_next;
	logic [DW-1:0]       diff;
	logic [AW-1:0]       raddr;
	logic                sub_now;

	logic                valid_s1;
	logic                start_s1;
	logic                full_s1;
	logic                sub_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] rdata_s1;

	logic [SUM_W-1:0]    sum_base;
	logic [SUM_W-1:0]    sum_next;

	logic                valid_s2;
	logic                start_s2;
	logic                full_s2;
	logic [SAMPLE_W-1:0] sample_s2;
	logic [SUM_W-1:0]    sum_s2;

	always_comb begin
		wp_base   = start ? '0 : wp_q;
		fill_base = start ? '0 : fill_q;
		sub_now   = (fill_base >= win);
		fill_next = sub_now ? fill_base : fill_base + 1'b1;
		diff      = DW'(wp_base) - DW'(win);
		if (DW'(wp_base) >= DW'(win)) begin
			raddr = AW'(diff);
		end else begin
			raddr = AW'(diff + DEPTH);
		end
	end

	// read-first: a full-depth window reads the entry being replaced
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_base] <= sample;
			rdata_s1     <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (clear) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wp_q   <= (wp_base == AW'(WINDOW_MAX - 1)) ? '0 : wp_base + 1'b1;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1  <= start;
			full_s1   <= (fill_next >= win);
			sub_s1    <= sub_now;
			sample_s1 <= sample;
		end
	end

	always_comb begin
		sum_base = start_s1 ? '0 : sum_q;
		sum_next = sum_base - (sub_s1 ? SUM_W'(rdata_s1) : '0) + SUM_W'(sample_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (en && valid_s1) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			start_s2  <= start_s1;
			full_s2   <= full_s1;
			sample_s2 <= sample_s1;
			sum_s2    <= sum_next;
		end
	end

	assign item_s2 = {valid_s2, start_s2, full_s2, sample_s2, sum_s2};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!clear && win == $past(win)) |-> fill_q <= win)
		else $error("fill count beyond window length");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(item_s2.valid))
		else $error("window stage moved during stall");

endmodule

`default_nettype wire

[hw/rtl/ens_detect.sv]
// ens_detect: threshold compare, arm state, segment count and sample index
// depends on ens_pkg; fed by ens_window, feeds the output skid buffer
`default_nettype none

module ens_detect (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire ens_pkg::win_item_t          item_s2,
	input  wire logic [ens_pkg::WIN_W-1:0]   win,
	input  wire logic [ens_pkg::CFG_W-1:0]   threshold,
	input  wire logic [ens_pkg::CFG_W-1:0]   floor_level,
	input  wire logic [ens_pkg::CFG_W-1:0]   limit,
	output logic                             res_valid,
	output ens_pkg::seg_result_t             res
);
	import ens_pkg::*;

	logic [SCALED_W-1:0] scaled_q;
	logic [INDEX_W-1:0]  pos_q;
	logic [INDEX_W-1:0]  rise_q;
	logic [SEG_W-1:0]    segs_q;
	logic                armed_q;

	logic [INDEX_W-1:0]  idx;
	logic [INDEX_W-1:0]  rise_base;
	logic [SEG_W-1:0]    segs_base;
	logic                armed_base;
	logic                active;
	logic                above;
	logic                below;
	logic                do_rise;
	logic                do_fall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaled_q <= '0;
		end else begin
			scaled_q <= SCALED_W'({15'd0, threshold} * {16'd0, win});
		end
	end

	always_comb begin
		idx        = item_s2.start ? '0 : pos_q;
		rise_base  = item_s2.start ? '0 : rise_q;
		segs_base  = item_s2.start ? '0 : segs_q;
		armed_base = item_s2.start ? 1'b0 : armed_q;
		active     = item_s2.full && (segs_base < limit);
		above      = {1'b0, item_s2.sum} > scaled_q;
		below      = {1'b0, item_s2.sum} < scaled_q;
		do_rise    = active && above && !armed_base;
		do_fall    = active && below && (item_s2.sample > floor_level) && armed_base;
		res_valid  = en && item_s2.valid && do_fall;
		res.onset_idx      = rise_base;
		res.offset_idx     = idx;
		res.segment_number = segs_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			rise_q  <= '0;
			segs_q  <= '0;
			armed_q <= 1'b0;
		end else if (en && item_s2.valid) begin
			pos_q <= (idx == INDEX_MAX) ? idx : idx + 1'b1;
			if (do_rise) begin
				armed_q <= 1'b1;
				rise_q  <= idx;
				segs_q  <= segs_base;
			end else if (do_fall) begin
				armed_q <= 1'b0;
				rise_q  <= rise_base;
				segs_q  <= segs_base + 1'b1;
			end else begin
				armed_q <= armed_base;
				rise_q  <= rise_base;
				segs_q  <= segs_base;
			end
		end
	end

	a_fall_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (item_s2.full && (item_s2.start || armed_q)))
		else $error("segment emitted while not armed");

	a_fall_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !armed_q)
		else $error("still armed after a segment");

endmodule

`default_nettype wire

[hw/rtl/ens_skid.sv]
// ens_skid: output register with one skid entry for the result channel
// depends on ens_pkg; ready toward the pipeline drops only when the skid entry is full
`default_nettype none

module ens_skid (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire ens_pkg::seg_result_t           push_data,
	output logic                                en,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ens_pkg::seg_result_t                out_data
);
	import ens_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	seg_result_t out_data_q;
	seg_result_t skid_data_q;

	assign en        = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid entry filled without a stall");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

endmodule

`default_nettype wire

[hw/rtl/envelope_note_segmenter.sv]
// envelope_note_segmenter: moving-average onset/offset note segmentation, top level
// depends on ens_pkg, ens_window, ens_detect, ens_skid
//
//  channel  direction  payload                                   handshake
//  s_*      in         tdata: sample; tuser: start_of_recording  tvalid/tready
//  m_*      out        tdata: onset_idx, offset_idx, segnum      tvalid/tready
//  cfg_*    in         index 0..3, data                          cfg_we, no wait
//
// one sample per cycle sustained while s_tready is high; the delay line ram does one read and one write per sample
// a sample passes the s1 and s2 window stage registers, then its result sets m_tvalid from the output register
// reset clears pointers, sums, indexes and registers; the delay line needs no clearing,
// entries are subtracted only once the fill count reaches the window length
// a stalled result moves to a skid entry; s_tready drops only while that entry is full
`default_nettype none

module envelope_note_segmenter #(
	parameter int WINDOW_MAX = 16384
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ens_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
	input  wire logic                            s_tuser,   // [0] start_of_recording
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ens_pkg::RESULT_W-1:0]         m_tdata,   // [31:0] onset_idx,
	                                                        // [63:32] offset_idx,
	                                                        // [79:64] segment_number
	input  wire logic                            cfg_we,
	input  wire logic [ens_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ens_pkg::CFG_W-1:0]       cfg_data
);
	import ens_pkg::*;

	logic [WIN_W-1:0] window_length_q;
	logic [CFG_W-1:0] threshold_q;
	logic [CFG_W-1:0] floor_q;
	logic [CFG_W-1:0] limit_q;

	logic [WIN_W-1:0] win;
	logic             clear;
	logic             en;
	logic             accept;
	win_item_t        item_s2;
	logic             res_valid;
	seg_result_t      res;
	seg_result_t      out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_RESET;
			threshold_q     <= THRESHOLD_RESET;
			floor_q         <= FLOOR_RESET;
			limit_q         <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WINDOW_LENGTH:     window_length_q <= cfg_data[WIN_W-1:0];
				CFG_LEVEL_THRESHOLD:   threshold_q     <= cfg_data;
				CFG_FALL_SAMPLE_FLOOR: floor_q         <= cfg_data;
				CFG_SEGMENT_LIMIT:     limit_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp window length to 1..WINDOW_MAX
	always_comb begin
		if (window_length_q == '0) begin
			win = WIN_W'(1);
		end else if (17'(window_length_q) > 17'(WINDOW_MAX)) begin
			win = WIN_W'(WINDOW_MAX);
		end else begin
			win = window_length_q;
		end
	end

	assign clear    = cfg_we && (cfg_idx_t'(cfg_index) == CFG_WINDOW_LENGTH);
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign m_tdata  = out_data;

	ens_window #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.accept  (accept),
		.sample  (s_tdata),
		.start   (s_tuser),
		.win     (win),
		.clear   (clear),
		.item_s2 (item_s2)
	);

	ens_detect u_detect (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.item_s2     (item_s2),
		.win         (win),
		.threshold   (threshold_q),
		.floor_level (floor_q),
		.limit       (limit_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	ens_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.en        (en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[tb/ens_tb_pkg.sv]
// ens_tb_pkg: segment tracker class that predicts and checks the segmenter's results
// depends on ens_pkg for field widths, reset values and register indexes
`timescale 1ns / 100ps

package ens_tb_pkg;

	import ens_pkg::*;

	localparam int RAM_DEPTH = 16384;

	class segment_tracker;
		seg_result_t       due_segments[$];
		bit [SAMPLE_W-1:0] history[RAM_DEPTH];
		bit [13:0]         wr_ptr;
		bit [WIN_W-1:0]    filled;
		bit [SUM_W-1:0]    level_sum;
		bit [INDEX_W-1:0]  position;
		bit                armed;
		bit [INDEX_W-1:0]  rise_at;
		bit [SEG_W-1:0]    seg_count;
		bit [WIN_W-1:0]    window_reg;
		bit [CFG_W-1:0]    threshold_reg;
		bit [CFG_W-1:0]    floor_reg;
		bit [CFG_W-1:0]    limit_reg;
		int                errors;

		function new();
			window_reg    = WINDOW_RESET;
			threshold_reg = THRESHOLD_RESET;
			floor_reg     = FLOOR_RESET;
			limit_reg     = LIMIT_RESET;
		endfunction

		function void clear_window();
			wr_ptr    = '0;
			filled    = '0;
			level_sum = '0;
		endfunction

		function int unsigned span();
			if (window_reg == 0)
				return 1;
			if (window_reg > RAM_DEPTH)
				return RAM_DEPTH;
			return window_reg;
		endfunction

		function void set_register(cfg_idx_t idx, bit [CFG_W-1:0] value);
			case (idx)
				CFG_WINDOW_LENGTH: begin
					window_reg = value[WIN_W-1:0];
					clear_window();
				end
				CFG_LEVEL_THRESHOLD:   threshold_reg = value;
				CFG_FALL_SAMPLE_FLOOR: floor_reg = value;
				CFG_SEGMENT_LIMIT:     limit_reg = value;
				default: ;
			endcase
		endfunction

		function void take_sample(bit [SAMPLE_W-1:0] smp, bit sor);
			int unsigned      w;
			bit [13:0]        oldest;
			longint unsigned  scaled;
			seg_result_t      seg;
			w = span();
			if (sor) begin
				clear_window();
				position  = '0;
				armed     = 1'b0;
				rise_at   = '0;
				seg_count = '0;
			end
			if (filled >= w) begin
				oldest = wr_ptr - w[13:0];
				level_sum -= history[oldest];
			end
			level_sum += smp;
			history[wr_ptr] = smp;
			wr_ptr++;
			if (filled < w)
				filled++;
			if (filled >= w && seg_count < limit_reg) begin
				scaled = threshold_reg;
				scaled = scaled * w;
				if (level_sum > scaled && !armed) begin
					armed   = 1'b1;
					rise_at = position;
				end
				if (level_sum < scaled && smp > floor_reg && armed) begin
					seg.onset_idx      = rise_at;
					seg.offset_idx     = position;
					seg.segment_number = seg_count;
					due_segments.push_back(seg);
					seg_count++;
					armed = 1'b0;
				end
			end
			if (position != INDEX_MAX)
				position++;
		endfunction

		function void match_segment(seg_result_t got);
			seg_result_t want;
			if (due_segments.size() == 0) begin
				errors++;
				$display("%0t unexpected segment: expected none, actual %0d %0d %0d",
					$time, got.onset_idx, got.offset_idx, got.segment_number);
				return;
			end
			want = due_segments.pop_front();
			if (got.onset_idx != want.onset_idx) begin
				errors++;
				$display("%0t onset_idx: expected %0d actual %0d",
					$time, want.onset_idx, got.onset_idx);
			end
			if (got.offset_idx != want.offset_idx) begin
				errors++;
				$display("%0t offset_idx: expected %0d actual %0d",
					$time, want.offset_idx, got.offset_idx);
			end
			if (got.segment_number != want.segment_number) begin
				errors++;
				$display("%0t segment_number: expected %0d actual %0d",
					$time, want.segment_number, got.segment_number);
			end
		endfunction

		function int pending();
			return due_segments.size();
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
// tb_top: drives samples and settings into envelope_note_segmenter and checks each segment
// depends on ens_pkg, ens_tb_pkg and the segmenter rtl
`timescale 1ns / 100ps

module tb_top;

	import ens_pkg::*;
	import ens_tb_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	cfg_idx_t            cfg_index = CFG_WINDOW_LENGTH;
	logic [CFG_W-1:0]    cfg_data = '0;

	segment_tracker tracker = new();

	bit tx_quiet;
	bit rx_quiet;
	int rx_hold;
	int fed;

	envelope_note_segmenter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall after each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				tracker.match_segment(seg_result_t'(m_tdata));
				rx_hold = rx_quiet ? 0 : $urandom_range(17, 0);
				if (rx_hold != 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (rx_hold > 0)
					rx_hold--;
				if (rx_hold == 0)
					m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(bit [SAMPLE_W-1:0] smp, bit sor);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(17, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= sor;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_sample(smp, sor);
		fed++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_settings(bit [CFG_W-1:0] win, bit [CFG_W-1:0] thr,
			bit [CFG_W-1:0] flo, bit [CFG_W-1:0] lim);
		bit [CFG_W-1:0] vals[4];
		vals = '{win, thr, flo, lim};
		drain();
		// samples that make no segment may still be in flight
		repeat (8) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			tracker.set_register(cfg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic bit [SAMPLE_W-1:0] draw_level(int unsigned lo, int unsigned hi);
		if ($urandom_range(15, 0) == 0)
			return SAMPLE_W'($urandom_range(65535, 0));
		return SAMPLE_W'($urandom_range(hi, lo));
	endfunction

	// loud stretch then quiet stretch, each at least as long as the window
	task automatic play_note(int unsigned w, bit [CFG_W-1:0] thr, bit [CFG_W-1:0] flo);
		int unsigned hi_lo;
		int unsigned hi_hi;
		int unsigned lo_lo;
		int unsigned lo_hi;
		int unsigned n;
		hi_lo = (thr + 1 > 65535) ? 65535 : thr + 1;
		hi_hi = (hi_lo * 2 > 65535) ? 65535 : hi_lo * 2;
		if (flo + 1 < thr) begin
			lo_lo = flo + 1;
			lo_hi = thr - 1;
		end else begin
			lo_lo = 0;
			lo_hi = 65535;
		end
		n = w + $urandom_range(3, 0);
		repeat (n) send_item(draw_level(hi_lo, hi_hi), $urandom_range(199, 0) == 0);
		n = w + $urandom_range(3, 0);
		repeat (n) send_item(draw_level(lo_lo, lo_hi), $urandom_range(199, 0) == 0);
	endtask

	initial begin
		bit [CFG_W-1:0] win;
		bit [CFG_W-1:0] thr;
		bit [CFG_W-1:0] flo;
		bit [CFG_W-1:0] lim;
		int             target;
		int             phase_end;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, window too long to fill
		send_item(16'h0000, 1'b1);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h7FFF, 1'b0);

		// window of zero acts as one, equal average neither rises nor falls
		write_settings(16'd0, 16'd1000, 16'd0, 16'd65535);
		send_item(16'hFFFF, 1'b1);
		send_item(16'd0, 1'b0);
		send_item(16'd500, 1'b0);
		send_item(16'd1000, 1'b0);
		send_item(16'd1001, 1'b0);
		send_item(16'd1000, 1'b0);
		send_item(16'd999, 1'b0);
		send_item(16'd0, 1'b1);

		// limit of one, then limit of zero
		write_settings(16'd1, 16'd100, 16'd0, 16'd1);
		send_item(16'd200, 1'b1);
		send_item(16'd50, 1'b0);
		send_item(16'd200, 1'b0);
		send_item(16'd50, 1'b0);
		write_settings(16'd1, 16'd100, 16'd0, 16'd0);
		send_item(16'd200, 1'b1);
		send_item(16'd50, 1'b0);

		// threshold and floor extremes
		write_settings(16'd1, 16'd0, 16'd65535, 16'd65535);
		send_item(16'd5, 1'b1);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		write_settings(16'd1, 16'd65535, 16'd0, 16'd65535);
		send_item(16'hFFFF, 1'b1);

		// largest window, written above range with the top bit set
		write_settings(16'hFFFF, 16'd199, 16'd50, 16'd65535);
		send_item(16'd200, 1'b1);
		send_item(16'd60, 1'b0);

		target = 950;
		while (fed < target) begin
			case ($urandom_range(7, 0))
				0: win = 16'd0;
				1: win = 16'd1;
				2, 3, 4: win = CFG_W'($urandom_range(8, 2));
				5, 6: win = CFG_W'($urandom_range(24, 9));
				default: win = CFG_W'($urandom_range(96, 25));
			endcase
			if ($urandom_range(7, 0) == 0)
				win[15] = 1'b1;
			case ($urandom_range(7, 0))
				0: thr = 16'd0;
				1: thr = 16'd65535;
				default: thr = CFG_W'($urandom_range(6000, 20));
			endcase
			case ($urandom_range(7, 0))
				0: flo = 16'd0;
				1: flo = 16'd65535;
				default: flo = CFG_W'($urandom_range(thr, 0));
			endcase
			case ($urandom_range(7, 0))
				0: lim = 16'd0;
				1, 2: lim = CFG_W'($urandom_range(3, 1));
				3: lim = CFG_W'($urandom_range(65535, 4));
				default: lim = 16'd65535;
			endcase
			write_settings(win, thr, flo, lim);
			tx_quiet = ($urandom_range(3, 0) == 0);
			rx_quiet = ($urandom_range(3, 0) == 0);
			phase_end = fed + $urandom_range(120, 40);
			while (fed < phase_end) begin
				if ($urandom_range(39, 0) == 0)
					drain();
				if ($urandom_range(7, 0) == 0)
					repeat ($urandom_range(8, 1))
						send_item(SAMPLE_W'($urandom_range(65535, 0)),
							$urandom_range(49, 0) == 0);
				else
					play_note(tracker.span(), thr, flo);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ens_pkg.sv
hw/rtl/ens_window.sv
hw/rtl/ens_detect.sv
hw/rtl/ens_skid.sv
hw/rtl/envelope_note_segmenter.sv
tb/ens_tb_pkg.sv
tb/tb_top.sv
